// ===== rtl/psso_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psso_pkg
// Shared types and constants of the pixel swap smoothness optimizer: image
// geometry, operation codes, beat payloads and the divider reciprocal.
// ----------------------------------------------------------------------------
package psso_pkg;

    localparam int IMAGE_WIDTH  = 80;
    localparam int IMAGE_HEIGHT = 100;
    localparam int PIX_TOTAL    = IMAGE_WIDTH * IMAGE_HEIGHT;

    localparam int ADDR_W  = 13;
    localparam int PIX_W   = 8;
    localparam int SCORE_W = 19;
    localparam int PAIR_W  = 20;
    localparam int CNT_W   = 32;
    localparam int COL_W   = $clog2(IMAGE_WIDTH);
    localparam int ROW_W   = $clog2(IMAGE_HEIGHT);

    // Row = (addr * RECIP) >> RECIP_SHIFT, low by at most one.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / IMAGE_WIDTH;

    localparam logic [ADDR_W-1:0] WIDTH_A    = ADDR_W'(IMAGE_WIDTH);
    localparam logic [ADDR_W-1:0] WRAP_V_A   = ADDR_W'((IMAGE_HEIGHT - 1) * IMAGE_WIDTH);
    localparam logic [ADDR_W-1:0] TOTAL_A    = ADDR_W'(PIX_TOTAL);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(IMAGE_HEIGHT - 1);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRY  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [PIX_W-1:0]  write_value;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]  read_value;
        logic              swap_kept;
        logic [PAIR_W-1:0] score_before;
        logic [PAIR_W-1:0] score_after;
        logic [CNT_W-1:0]  attempt_count;
    } t_out_item;

    // Centre and its four wrapped neighbors, as addresses or as pixels.
    typedef struct packed {
        logic [ADDR_W-1:0] c;
        logic [ADDR_W-1:0] l;
        logic [ADDR_W-1:0] r;
        logic [ADDR_W-1:0] u;
        logic [ADDR_W-1:0] d;
    } t_nbr_addr;

    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] l;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] d;
    } t_pt_vals;

endpackage
`default_nettype wire

// ===== rtl/psso_pixel_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psso_pixel_mem
// Pixel store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psso_pixel_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [psso_pkg::ADDR_W-1:0]    i_wr_addr,
    input  wire logic [psso_pkg::PIX_W-1:0]     i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [psso_pkg::ADDR_W-1:0]    i_rd_addr,
    output      logic [psso_pkg::PIX_W-1:0]     o_rd_data
);

    logic [psso_pkg::PIX_W-1:0] r_mem [psso_pkg::PIX_TOTAL];
    logic [psso_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/psso_nbr_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psso_nbr_addr
// Three-stage pipeline that splits a pixel address into row and column and
// forms the addresses of its four neighbors on the torus.
// ----------------------------------------------------------------------------
module psso_nbr_addr (
    input  wire logic                           i_clk,
    input  wire logic [psso_pkg::ADDR_W-1:0]    i_addr,
    output      psso_pkg::t_nbr_addr            o_nbr
);

    localparam int PROD_W = psso_pkg::ADDR_W + psso_pkg::RECIP_W;

    logic [PROD_W-1:0]               w_prod;
    logic [psso_pkg::ADDR_W-1:0]     r1_addr;
    logic [psso_pkg::ROW_W-1:0]      r1_row;
    logic [psso_pkg::ADDR_W-1:0]     w_row_base;
    logic [psso_pkg::ADDR_W-1:0]     w_rem;
    logic [psso_pkg::ADDR_W-1:0]     r2_addr;
    logic [psso_pkg::ROW_W-1:0]      r2_row;
    logic [psso_pkg::COL_W:0]        r2_rem;
    logic                            w_fix;
    logic [psso_pkg::COL_W:0]        w_col_full;
    logic [psso_pkg::COL_W-1:0]      w_col;
    logic [psso_pkg::ROW_W-1:0]      w_row;
    psso_pkg::t_nbr_addr             n_nbr;
    psso_pkg::t_nbr_addr             r_nbr;

    // Stage 1: reciprocal multiply gives the row estimate.
    assign w_prod = PROD_W'(i_addr) * PROD_W'(psso_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        r1_addr <= i_addr;
        r1_row  <= w_prod[psso_pkg::RECIP_SHIFT +: psso_pkg::ROW_W];
    end

    // Stage 2: remainder against the estimated row.
    assign w_row_base = psso_pkg::ADDR_W'(r1_row) * psso_pkg::WIDTH_A;
    assign w_rem      = r1_addr - w_row_base;

    always_ff @(posedge i_clk) begin
        r2_addr <= r1_addr;
        r2_row  <= r1_row;
        r2_rem  <= w_rem[psso_pkg::COL_W:0];
    end

    // Stage 3: one correction step, then the wrapped neighbors.
    assign w_fix      = r2_rem >= (psso_pkg::COL_W + 1)'(psso_pkg::IMAGE_WIDTH);
    assign w_col_full = w_fix ? r2_rem - (psso_pkg::COL_W + 1)'(psso_pkg::IMAGE_WIDTH)
                              : r2_rem;
    assign w_col      = w_col_full[psso_pkg::COL_W-1:0];
    assign w_row      = w_fix ? r2_row + psso_pkg::ROW_W'(1) : r2_row;

    always_comb begin
        n_nbr.c = r2_addr;
        n_nbr.l = (w_col == '0) ? r2_addr + psso_pkg::WIDTH_A - psso_pkg::ADDR_W'(1)
                                : r2_addr - psso_pkg::ADDR_W'(1);
        n_nbr.r = (w_col == psso_pkg::COL_LAST)
                  ? r2_addr - psso_pkg::WIDTH_A + psso_pkg::ADDR_W'(1)
                  : r2_addr + psso_pkg::ADDR_W'(1);
        n_nbr.u = (w_row == '0) ? r2_addr + psso_pkg::WRAP_V_A
                                : r2_addr - psso_pkg::WIDTH_A;
        n_nbr.d = (w_row == psso_pkg::ROW_LAST) ? r2_addr - psso_pkg::WRAP_V_A
                                                : r2_addr + psso_pkg::WIDTH_A;
    end

    always_ff @(posedge i_clk) begin
        r_nbr <= n_nbr;
    end

    assign o_nbr = r_nbr;

endmodule
`default_nettype wire

// ===== rtl/psso_point_score.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psso_point_score
// Two-stage pipeline scoring one point as h*h + v*v from its centre and
// four neighbor pixels.
// ----------------------------------------------------------------------------
module psso_point_score (
    input  wire logic                           i_clk,
    input  wire psso_pkg::t_pt_vals             i_vals,
    output      logic [psso_pkg::SCORE_W-1:0]   o_score
);

    logic signed [10:0]              n_h;
    logic signed [10:0]              n_v;
    logic signed [10:0]              r_h;
    logic signed [10:0]              r_v;
    logic signed [21:0]              w_hh;
    logic signed [21:0]              w_vv;
    logic [psso_pkg::SCORE_W-1:0]    r_score;

    // Second differences fit in 11 bits signed.
    always_comb begin
        n_h = signed'({3'b000, i_vals.l}) + signed'({3'b000, i_vals.r})
            - signed'({2'b00, i_vals.c, 1'b0});
        n_v = signed'({3'b000, i_vals.u}) + signed'({3'b000, i_vals.d})
            - signed'({2'b00, i_vals.c, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_v <= n_v;
    end

    assign w_hh = r_h * r_h;
    assign w_vv = r_v * r_v;

    always_ff @(posedge i_clk) begin
        r_score <= w_hh[psso_pkg::SCORE_W-1:0] + w_vv[psso_pkg::SCORE_W-1:0];
    end

    assign o_score = r_score;

endmodule
`default_nettype wire

// ===== rtl/pixel_swap_smoothness_optimizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_swap_smoothness_optimizer
// Image store on a torus with load, read and scored swap-try operations.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A load or a read presents its result
// after its load or read state and the result register, and the next beat
// can be accepted once the result register is loaded. A swap try with both
// addresses in range runs the neighbor address pipeline, fetches the ten
// pixels through the single read port of the pixel memory, runs the score
// pipeline, decides, writes back a kept swap (an undone swap skips this) and
// loads the result register. A try with an address outside the image, or an
// unused op code, goes straight to the result register. The result register
// lets a new beat be accepted while the previous result is still stalled at
// the output. Pixels that were never loaded read back as undefined values.
// ----------------------------------------------------------------------------
module pixel_swap_smoothness_optimizer (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output      logic                   o_in_stall,
    input  wire psso_pkg::t_in_item     i_in_data,
    output      logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    output      psso_pkg::t_out_item    o_out_data
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOAD   = 10'b00_0000_0010,
        S_RD     = 10'b00_0000_0100,
        S_AGEN   = 10'b00_0000_1000,
        S_FETCH  = 10'b00_0001_0000,
        S_SCORE  = 10'b00_0010_0000,
        S_DECIDE = 10'b00_0100_0000,
        S_WRA    = 10'b00_1000_0000,
        S_WRB    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    localparam int NPIX = 10;

    t_state                             r_state;
    t_state                             n_state;
    logic [3:0]                         r_step;
    logic [3:0]                         n_step;

    logic [1:0]                         r_op;
    logic [psso_pkg::ADDR_W-1:0]        r_a;
    logic [psso_pkg::ADDR_W-1:0]        r_b;
    logic [psso_pkg::PIX_W-1:0]         r_wv;
    logic                               r_a_ok;
    logic                               r_b_ok;
    logic [psso_pkg::CNT_W-1:0]         r_try_cnt;

    logic [psso_pkg::ADDR_W-1:0]        r_nbr [NPIX];
    logic [psso_pkg::PIX_W-1:0]         r_val [NPIX];
    logic [psso_pkg::PIX_W-1:0]         w_sub [NPIX];
    logic [psso_pkg::SCORE_W-1:0]       r_sc  [4];

    logic                               r_kept;
    logic [psso_pkg::PAIR_W-1:0]        r_before;
    logic [psso_pkg::PAIR_W-1:0]        r_after;
    logic [psso_pkg::PAIR_W-1:0]        w_before;
    logic [psso_pkg::PAIR_W-1:0]        w_after;

    logic                               r_out_valid;
    psso_pkg::t_out_item                r_out;

    logic                               w_accept;
    logic                               w_out_free;

    logic                               w_wr_en;
    logic [psso_pkg::ADDR_W-1:0]        w_wr_addr;
    logic [psso_pkg::PIX_W-1:0]         w_wr_data;
    logic                               w_rd_en;
    logic [psso_pkg::ADDR_W-1:0]        w_rd_addr;
    logic [psso_pkg::PIX_W-1:0]         w_rd_data;

    logic [psso_pkg::ADDR_W-1:0]        w_agen_addr;
    psso_pkg::t_nbr_addr                w_nbr;
    psso_pkg::t_pt_vals                 w_pt;
    logic [psso_pkg::SCORE_W-1:0]       w_score;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    psso_pixel_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_agen_addr = (r_step == 4'd0) ? r_a : r_b;

    psso_nbr_addr u_nbr (
        .i_clk  (i_clk),
        .i_addr (w_agen_addr),
        .o_nbr  (w_nbr)
    );

    psso_point_score u_score (
        .i_clk   (i_clk),
        .i_vals  (w_pt),
        .o_score (w_score)
    );

    // ------------------------------------------------------------------
    // Pixel values as they stand once the swap is applied.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NPIX; k++) begin
            if (r_nbr[k] == r_a) begin
                w_sub[k] = r_val[5];
            end else if (r_nbr[k] == r_b) begin
                w_sub[k] = r_val[0];
            end else begin
                w_sub[k] = r_val[k];
            end
        end
    end

    // Score order: a before, b before, a after, b after.
    always_comb begin
        unique case (r_step[1:0])
            2'd0: w_pt = {r_val[0], r_val[1], r_val[2], r_val[3], r_val[4]};
            2'd1: w_pt = {r_val[5], r_val[6], r_val[7], r_val[8], r_val[9]};
            2'd2: w_pt = {w_sub[0], w_sub[1], w_sub[2], w_sub[3], w_sub[4]};
            default: w_pt = {w_sub[5], w_sub[6], w_sub[7], w_sub[8], w_sub[9]};
        endcase
    end

    assign w_before = psso_pkg::PAIR_W'(r_sc[0]) + psso_pkg::PAIR_W'(r_sc[1]);
    assign w_after  = psso_pkg::PAIR_W'(r_sc[2]) + psso_pkg::PAIR_W'(r_sc[3]);

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_a;
        w_wr_data = r_wv;
        w_rd_en   = 1'b0;
        w_rd_addr = r_a;
        unique case (r_state)
            S_LOAD: begin
                w_wr_en = r_a_ok;
            end
            S_RD: begin
                w_rd_en = r_a_ok;
            end
            S_FETCH: begin
                w_rd_en   = (r_step < 4'(NPIX));
                w_rd_addr = (r_step < 4'(NPIX)) ? r_nbr[r_step] : r_a;
            end
            S_WRA: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_val[5];
            end
            S_WRB: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_b;
                w_wr_data = r_val[0];
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_step  = r_step + 4'd1;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    unique case (i_in_data.op)
                        psso_pkg::OP_LOAD: n_state = S_LOAD;
                        psso_pkg::OP_READ: n_state = S_RD;
                        psso_pkg::OP_TRY: begin
                            if (i_in_data.addr_a < psso_pkg::TOTAL_A &&
                                i_in_data.addr_b < psso_pkg::TOTAL_A) begin
                                n_state = S_AGEN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD:  n_state = S_DONE;
            S_RD:    n_state = S_DONE;
            S_AGEN: begin
                if (r_step == 4'd4) begin
                    n_state = S_FETCH;
                    n_step  = '0;
                end
            end
            S_FETCH: begin
                if (r_step == 4'(NPIX)) begin
                    n_state = S_SCORE;
                    n_step  = '0;
                end
            end
            S_SCORE: begin
                if (r_step == 4'd5) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = (w_after <= w_before) ? S_WRA : S_DONE;
            S_WRA:    n_state = S_WRB;
            S_WRB:    n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_try_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_accept && i_in_data.op == psso_pkg::OP_TRY) begin
                r_try_cnt <= r_try_cnt + psso_pkg::CNT_W'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in_data.op;
            r_a      <= i_in_data.addr_a;
            r_b      <= i_in_data.addr_b;
            r_wv     <= i_in_data.write_value;
            r_a_ok   <= i_in_data.addr_a < psso_pkg::TOTAL_A;
            r_b_ok   <= i_in_data.addr_b < psso_pkg::TOTAL_A;
            r_kept   <= 1'b0;
            r_before <= '0;
            r_after  <= '0;
        end
        if (r_state == S_AGEN && r_step == 4'd3) begin
            {r_nbr[0], r_nbr[1], r_nbr[2], r_nbr[3], r_nbr[4]} <= w_nbr;
        end
        if (r_state == S_AGEN && r_step == 4'd4) begin
            {r_nbr[5], r_nbr[6], r_nbr[7], r_nbr[8], r_nbr[9]} <= w_nbr;
        end
        // Read data is registered and arrives in the step after its address.
        if (r_state == S_FETCH && r_step != 4'd0) begin
            r_val[r_step - 4'd1] <= w_rd_data;
        end
        // Point scores are captured as they leave the score pipeline, in the order fed.
        if (r_state == S_SCORE && r_step >= 4'd2) begin
            r_sc[2'(r_step - 4'd2)] <= w_score;
        end
        if (r_state == S_DECIDE) begin
            r_before <= w_before;
            r_after  <= w_after;
            r_kept   <= (w_after <= w_before);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.read_value    <= (r_op == psso_pkg::OP_READ && r_a_ok) ? w_rd_data : '0;
            r_out.swap_kept     <= r_kept;
            r_out.score_before  <= r_before;
            r_out.score_after   <= r_after;
            r_out.attempt_count <= r_try_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_kept_not_worse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.swap_kept |->
            o_out_data.score_after <= o_out_data.score_before)
        else $error("kept swap has a higher score");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_try_cnt != $past(r_try_cnt)) |->
            (r_try_cnt == $past(r_try_cnt) + psso_pkg::CNT_W'(1)))
        else $error("attempt counter moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    a_writeback_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRA) |-> ($past(r_state) == S_DECIDE) && r_kept && r_a_ok && r_b_ok)
        else $error("write-back without a kept decision");

endmodule
`default_nettype wire
